@@ hw/rtl/cps_pkg.sv @@
// Shared types and codes for the class priority request scheduler.
package cps_pkg;

	// Widest tag and slot index the cell chain carries
	localparam int TAG_MAX = 64;
	localparam int IDX_MAX = 8;
	// Window compare width, holds 0..256
	localparam int WIN_W   = 9;
	localparam int HND_W   = 16;

	// Operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_TAKE   = 1'b1;

	// Request classes
	localparam logic CLASS_TEXT  = 1'b0;
	localparam logic CLASS_IMAGE = 1'b1;

	// Scheduling policies
	localparam logic [1:0] POL_ANY    = 2'd0;
	localparam logic [1:0] POL_OLDEST = 2'd1;
	localparam logic [1:0] POL_IMAGE  = 2'd2;
	localparam logic [1:0] POL_TEXT   = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_WINDOW = 2'd1;

	// One candidate found so far along the chain
	typedef struct packed {
		logic               hit;
		logic [TAG_MAX-1:0] tag;
		logic               cls;
		logic [HND_W-1:0]   hnd;
		logic [IDX_MAX-1:0] idx;
	} cps_cand_t;

	// Token handed from cell to cell
	typedef struct packed {
		cps_cand_t          any_c;
		cps_cand_t          cls_c;
		logic               free_hit;
		logic [IDX_MAX-1:0] free_idx;
	} cps_tok_t;

	// Broadcast update to the slot cells
	typedef struct packed {
		logic               en;
		logic               set;
		logic [IDX_MAX-1:0] idx;
		logic [TAG_MAX-1:0] tag;
		logic               cls;
		logic [HND_W-1:0]   hnd;
	} cps_wr_t;

endpackage

@@ hw/rtl/cps_cell.sv @@
// One slot of the request table with its stage of the oldest/free search.
module cps_cell import cps_pkg::*; #(
	parameter int TAG_BITS = 32,
	parameter int IDX      = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WIN_W-1:0] win,
	input  logic             want_cls,
	input  cps_wr_t          wr,
	input  cps_tok_t         tok_in,
	output cps_tok_t         tok_out
);

	localparam logic [IDX_MAX-1:0] MY_IDX = IDX_MAX'(IDX);

	logic                valid_q;
	logic [TAG_BITS-1:0] tag_q;
	logic                cls_q;
	logic [HND_W-1:0]    hnd_q;
	cps_tok_t            tok_q;

	logic      in_win;
	logic      wr_hit;
	cps_cand_t own;
	cps_tok_t  tok_d;

	assign in_win = (WIN_W'(IDX) < win);
	assign wr_hit = wr.en && (wr.idx == MY_IDX);

	// Slot contents; valid bit is the only reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_hit) begin
			valid_q <= wr.set;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit && wr.set) begin
			tag_q <= wr.tag[TAG_BITS-1:0];
			cls_q <= wr.cls;
			hnd_q <= wr.hnd;
		end
	end

	// Merge own entry into the passing token; strict less keeps lower slot on ties
	always_comb begin
		own.hit = valid_q && in_win;
		own.tag = TAG_MAX'(tag_q);
		own.cls = cls_q;
		own.hnd = hnd_q;
		own.idx = MY_IDX;
		tok_d   = tok_in;
		if (own.hit && (!tok_in.any_c.hit || own.tag < tok_in.any_c.tag)) begin
			tok_d.any_c = own;
		end
		if (own.hit && (cls_q == want_cls) &&
			(!tok_in.cls_c.hit || own.tag < tok_in.cls_c.tag)) begin
			tok_d.cls_c = own;
		end
		if (!tok_in.free_hit && in_win && !valid_q) begin
			tok_d.free_hit = 1'b1;
			tok_d.free_idx = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

@@ hw/rtl/class_priority_request_scheduler.sv @@
// Top level: request table as a chain of slot cells plus the operation sequencer.
// An accepted word's result is registered once the search token has walked the cell chain
// one slot per cycle and the sequencer commits in its finish state.
// A new word is accepted only in the idle state; one operation is in flight at a time.
// Reset: arst_n clears all valid bits, fill and dispatch counts; policy resets
// to oldest first and the window to 16 slots. Tags and handles are not reset.
module class_priority_request_scheduler import cps_pkg::*; #(
	parameter int SLOTS    = 16,
	parameter int TAG_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [4:0]  cfg_wdata,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // request_tag[31:0], request_class[32], connection_handle[48:33]
	input  logic        s_tuser,   // operation
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // out_tag[31:0], out_class[32], out_handle[48:33],
	                               // dispatch_number[80:49], occupancy[85:81]
	output logic        m_tuser    // done_res
);

	localparam int CW = $clog2(SLOTS + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]          state_q;
	logic [CW-1:0]       cnt_q;
	logic [1:0]          policy_q;
	logic [4:0]          slots_q;
	logic [WIN_W-1:0]    fill_q;
	logic [31:0]         disp_q;
	logic                op_q;
	logic [TAG_BITS-1:0] req_tag_q;
	logic                req_cls_q;
	logic [HND_W-1:0]    req_hnd_q;
	logic                mvalid_q;
	logic [87:0]         mdata_q;
	logic                mdone_q;

	logic [WIN_W-1:0]     win;
	logic                 want_cls;
	logic                 class_pol;
	logic                 out_free;
	logic                 commit;
	cps_tok_t             tail;
	cps_cand_t            pick;
	cps_wr_t              wr;
	logic                 done;
	logic [TAG_BITS+31:0] tag_in_ext;
	logic [TAG_MAX+31:0]  tag_out_ext;
	logic [87:0]          mdata_d;

	cps_tok_t tok [0:SLOTS];

	// Clamp the window to 1..SLOTS
	always_comb begin
		if (slots_q == 5'd0) begin
			win = WIN_W'(1);
		end else if (WIN_W'(slots_q) > WIN_W'(SLOTS)) begin
			win = WIN_W'(SLOTS);
		end else begin
			win = WIN_W'(slots_q);
		end
	end

	assign class_pol = (policy_q == POL_IMAGE) || (policy_q == POL_TEXT);
	assign want_cls  = (policy_q == POL_TEXT) ? CLASS_TEXT : CLASS_IMAGE;

	// Cell chain; an empty token enters at slot zero every cycle
	assign tok[0] = '0;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		cps_cell #(
			.TAG_BITS (TAG_BITS),
			.IDX      (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.win      (win),
			.want_cls (want_cls),
			.wr       (wr),
			.tok_in   (tok[g]),
			.tok_out  (tok[g+1])
		);
	end

	assign tail = tok[SLOTS];

	// Choose the request to take from the tail token
	always_comb begin
		if (class_pol && tail.cls_c.hit) begin
			pick = tail.cls_c;
		end else begin
			pick = tail.any_c;
		end
	end

	assign out_free = !mvalid_q || m_tready;
	assign commit   = (state_q == ST_FINISH) && out_free;
	assign done     = (op_q == OP_INSERT) ? tail.free_hit : pick.hit;

	// Table update issued when the result is loaded
	always_comb begin
		wr.en  = commit && done;
		wr.set = (op_q == OP_INSERT);
		wr.idx = (op_q == OP_INSERT) ? tail.free_idx : pick.idx;
		wr.tag = TAG_MAX'(req_tag_q);
		wr.cls = req_cls_q;
		wr.hnd = req_hnd_q;
	end

	assign tag_in_ext  = {{TAG_BITS{1'b0}}, s_tdata[31:0]};
	assign tag_out_ext = {32'd0, pick.tag};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_OLDEST;
			slots_q  <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_POLICY: policy_q <= cfg_wdata[1:0];
				REG_WINDOW: slots_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q      <= s_tuser;
			req_tag_q <= tag_in_ext[TAG_BITS-1:0];
			req_cls_q <= s_tdata[32];
			req_hnd_q <= s_tdata[48:33];
		end
	end

	// Sequencer: wait for the token to cross the chain, then commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			fill_q  <= '0;
			disp_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(SLOTS)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (done) begin
							if (op_q == OP_INSERT) begin
								fill_q <= fill_q + 1'b1;
							end else begin
								fill_q <= fill_q - 1'b1;
								disp_q <= disp_q + 32'd1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	// Result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (commit) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	// Result word contents for the operation being committed
	always_comb begin
		mdata_d = '0;
		if (op_q == OP_INSERT) begin
			mdata_d[85:81] = tail.free_hit ? fill_q[4:0] + 5'd1 : fill_q[4:0];
		end else if (pick.hit) begin
			mdata_d[31:0]  = tag_out_ext[31:0];
			mdata_d[32]    = pick.cls;
			mdata_d[48:33] = pick.hnd;
			mdata_d[80:49] = disp_q;
			mdata_d[85:81] = fill_q[4:0] - 5'd1;
		end else begin
			mdata_d[85:81] = fill_q[4:0];
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			mdone_q <= done;
			mdata_q <= mdata_d;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;
	assign m_tuser  = mdone_q;

endmodule

@@ bench/class_priority_request_scheduler_tb.sv @@
// Self-checking bench for the class priority request scheduler: directed table, then random traffic.
module class_priority_request_scheduler_tb import cps_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS          = 16;
	localparam int HOLD_CYCLES    = 60;
	localparam int QUIET_LIMIT    = 2000;
	localparam int PHASES         = 12;
	localparam int PHASE_WORDS    = 152;
	localparam int MAX_REPORTS    = 50;

	// Index slots with no register behind them
	localparam logic [1:0] REG_UNMAPPED_A = 2'd2;
	localparam logic [1:0] REG_UNMAPPED_B = 2'd3;

	// One scheduler result word, fields as the result stream carries them
	typedef struct packed {
		logic        done;
		logic [31:0] tag;
		logic        cls;
		logic [15:0] hnd;
		logic [31:0] num;
		logic [4:0]  occ;
	} outcome_t;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	// Directed row: a request word or a register write; typed rows carry their result
	typedef struct packed {
		row_kind_t   kind;
		logic        op;
		logic [31:0] tag;
		logic        cls;
		logic [15:0] hnd;
		logic [1:0]  addr;
		logic [4:0]  val;
		logic        typed;
		outcome_t    want;
	} step_row_t;

	localparam outcome_t NO_OUTCOME = '0;

	localparam step_row_t DIRECTED [33] = '{
		// empty table after reset
		'{ROW_WORD, OP_TAKE, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, 5'd0, 1'b1,
			'{1'b0, 32'h0, CLASS_TEXT, 16'h0, 32'd0, 5'd0}},
		// extreme and minimum fields, then two equal tags
		'{ROW_WORD, OP_INSERT, 32'hFFFF_FFFF, CLASS_IMAGE, 16'hFFFF, REG_POLICY, 5'd0, 1'b1,
			'{1'b1, 32'h0, CLASS_TEXT, 16'h0, 32'd0, 5'd1}},
		'{ROW_WORD, OP_INSERT, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, 5'd0, 1'b1,
			'{1'b1, 32'h0, CLASS_TEXT, 16'h0, 32'd0, 5'd2}},
		'{ROW_WORD, OP_INSERT, 32'h5, CLASS_IMAGE, 16'h1234, REG_POLICY, 5'd0, 1'b1,
			'{1'b1, 32'h0, CLASS_TEXT, 16'h0, 32'd0, 5'd3}},
		'{ROW_WORD, OP_INSERT, 32'h5, CLASS_TEXT, 16'hABCD, REG_POLICY, 5'd0, 1'b1,
			'{1'b1, 32'h0, CLASS_TEXT, 16'h0, 32'd0, 5'd4}},
		'{ROW_WORD, OP_TAKE, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, 5'd0, 1'b1,
			'{1'b1, 32'h0, CLASS_TEXT, 16'h0, 32'd0, 5'd3}},
		// tie on tag goes to the lower slot
		'{ROW_WORD, OP_TAKE, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, 5'd0, 1'b0, NO_OUTCOME},
		// upper data bits set: policy masks to image first
		'{ROW_REG, OP_INSERT, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, 5'h1E, 1'b0, NO_OUTCOME},
		'{ROW_WORD, OP_TAKE, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, 5'd0, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, CLASS_IMAGE, 16'hFFFF, 32'd2, 5'd1}},
		// no image left: falls back to oldest overall
		'{ROW_WORD, OP_TAKE, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, 5'd0, 1'b0, NO_OUTCOME},
		'{ROW_REG, OP_INSERT, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, {3'd0, POL_TEXT}, 1'b0,
			NO_OUTCOME},
		'{ROW_WORD, OP_INSERT, 32'h7, CLASS_IMAGE, 16'h00F0, REG_POLICY, 5'd0, 1'b0, NO_OUTCOME},
		'{ROW_WORD, OP_TAKE, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, 5'd0, 1'b0, NO_OUTCOME},
		'{ROW_REG, OP_INSERT, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, {3'd0, POL_ANY}, 1'b0,
			NO_OUTCOME},
		'{ROW_WORD, OP_INSERT, 32'h9, CLASS_TEXT, 16'h5A5A, REG_POLICY, 5'd0, 1'b0, NO_OUTCOME},
		'{ROW_WORD, OP_INSERT, 32'h3, CLASS_IMAGE, 16'hA5A5, REG_POLICY, 5'd0, 1'b0, NO_OUTCOME},
		'{ROW_WORD, OP_TAKE, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, 5'd0, 1'b0, NO_OUTCOME},
		// writes to unmapped indexes must change nothing
		'{ROW_REG, OP_INSERT, 32'h0, CLASS_TEXT, 16'h0, REG_UNMAPPED_A, 5'h1E, 1'b0, NO_OUTCOME},
		'{ROW_REG, OP_INSERT, 32'h0, CLASS_TEXT, 16'h0, REG_UNMAPPED_B, 5'h1F, 1'b0, NO_OUTCOME},
		// one-slot window already full
		'{ROW_REG, OP_INSERT, 32'h0, CLASS_TEXT, 16'h0, REG_WINDOW, 5'd1, 1'b0, NO_OUTCOME},
		'{ROW_WORD, OP_INSERT, 32'h11, CLASS_TEXT, 16'h1111, REG_POLICY, 5'd0, 1'b1,
			'{1'b0, 32'h0, CLASS_TEXT, 16'h0, 32'd0, 5'd1}},
		'{ROW_WORD, OP_TAKE, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, 5'd0, 1'b0, NO_OUTCOME},
		// window of zero acts as one slot
		'{ROW_REG, OP_INSERT, 32'h0, CLASS_TEXT, 16'h0, REG_WINDOW, 5'd0, 1'b0, NO_OUTCOME},
		'{ROW_WORD, OP_INSERT, 32'h8000_0000, CLASS_TEXT, 16'h8000, REG_POLICY, 5'd0, 1'b0,
			NO_OUTCOME},
		'{ROW_WORD, OP_INSERT, 32'h22, CLASS_IMAGE, 16'h2222, REG_POLICY, 5'd0, 1'b1,
			'{1'b0, 32'h0, CLASS_TEXT, 16'h0, 32'd0, 5'd1}},
		// window above the table size acts as the full table
		'{ROW_REG, OP_INSERT, 32'h0, CLASS_TEXT, 16'h0, REG_WINDOW, 5'd31, 1'b0, NO_OUTCOME},
		'{ROW_WORD, OP_INSERT, 32'h7FFF_FFFF, CLASS_IMAGE, 16'h7FFF, REG_POLICY, 5'd0, 1'b0,
			NO_OUTCOME},
		// shrunk window hides slot 1 but occupancy still counts it
		'{ROW_REG, OP_INSERT, 32'h0, CLASS_TEXT, 16'h0, REG_WINDOW, 5'd1, 1'b0, NO_OUTCOME},
		'{ROW_WORD, OP_TAKE, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, 5'd0, 1'b0, NO_OUTCOME},
		'{ROW_WORD, OP_TAKE, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, 5'd0, 1'b1,
			'{1'b0, 32'h0, CLASS_TEXT, 16'h0, 32'd0, 5'd1}},
		'{ROW_REG, OP_INSERT, 32'h0, CLASS_TEXT, 16'h0, REG_WINDOW, 5'd16, 1'b0, NO_OUTCOME},
		'{ROW_WORD, OP_TAKE, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, 5'd0, 1'b0, NO_OUTCOME},
		'{ROW_REG, OP_INSERT, 32'h0, CLASS_TEXT, 16'h0, REG_POLICY, {3'd0, POL_OLDEST}, 1'b0,
			NO_OUTCOME}
	};

	// Settings walked by the random phases
	localparam logic [1:0] PHASE_POLICY [PHASES] = '{POL_ANY, POL_OLDEST, POL_IMAGE, POL_TEXT,
		POL_OLDEST, POL_IMAGE, POL_TEXT, POL_ANY, POL_IMAGE, POL_TEXT, POL_OLDEST, POL_IMAGE};
	localparam logic [4:0] PHASE_WINDOW [PHASES] = '{5'd16, 5'd1, 5'd8, 5'd0, 5'd31, 5'd4,
		5'd16, 5'd2, 5'd12, 5'd17, 5'd16, 5'd3};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [4:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;   // request_tag[31:0], request_class[32], connection_handle[48:33]
	logic        s_tuser = 1'b0; // operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;        // out_tag[31:0], out_class[32], out_handle[48:33],
	                             // dispatch_number[80:49], occupancy[85:81]
	logic        m_tuser;        // done_res

	class_priority_request_scheduler #(.SLOTS(SLOTS), .TAG_BITS(32)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Shadow of the slot table and registers
	bit          tbl_valid [SLOTS];
	logic [31:0] tbl_tag   [SLOTS];
	logic        tbl_cls   [SLOTS];
	logic [15:0] tbl_hnd   [SLOTS];
	int unsigned tbl_fill;
	logic [31:0] take_count;
	logic [1:0]  cur_policy;
	logic [4:0]  cur_window;

	outcome_t    awaited_results [$];
	int          in_flight = 0;
	int unsigned errors = 0;
	int unsigned words_sent = 0;
	int unsigned takes_served = 0;
	int unsigned refused = 0;
	int unsigned quiet = 0;
	logic [31:0] arrival = '0;
	bit          bursty = 1'b1;
	bit          hold_rx = 1'b0;
	outcome_t    got, want;

	initial begin
		forever #1 clk = ~clk;
	end

	// Active window after clamping to 1..SLOTS
	function automatic int eff_window();
		if (cur_window == 5'd0)
			return 1;
		if (int'(cur_window) > SLOTS)
			return SLOTS;
		return int'(cur_window);
	endfunction

	// Lowest slot holding the smallest tag in the window, optionally of one class
	function automatic int oldest_slot(bit by_class, logic want_cls);
		int best;
		best = -1;
		for (int i = 0; i < eff_window(); i++) begin
			if (tbl_valid[i] && (!by_class || tbl_cls[i] == want_cls)) begin
				if (best < 0 || tbl_tag[i] < tbl_tag[best])
					best = i;
			end
		end
		return best;
	endfunction

	// Apply one operation to the shadow table and return the result word it gives
	function automatic outcome_t sched_outcome(logic op, logic [31:0] tag, logic cls,
			logic [15:0] hnd);
		outcome_t r;
		int pick;
		r = '0;
		if (op == OP_INSERT) begin
			for (int i = 0; i < eff_window(); i++) begin
				if (!tbl_valid[i]) begin
					tbl_valid[i] = 1'b1;
					tbl_tag[i]   = tag;
					tbl_cls[i]   = cls;
					tbl_hnd[i]   = hnd;
					tbl_fill++;
					r.done = 1'b1;
					break;
				end
			end
		end else begin
			pick = -1;
			if (cur_policy == POL_IMAGE)
				pick = oldest_slot(1'b1, CLASS_IMAGE);
			else if (cur_policy == POL_TEXT)
				pick = oldest_slot(1'b1, CLASS_TEXT);
			if (pick < 0)
				pick = oldest_slot(1'b0, CLASS_TEXT);
			if (pick >= 0) begin
				tbl_valid[pick] = 1'b0;
				r.done = 1'b1;
				r.tag  = tbl_tag[pick];
				r.cls  = tbl_cls[pick];
				r.hnd  = tbl_hnd[pick];
				r.num  = take_count;
				take_count++;
				if (tbl_fill > 0)
					tbl_fill--;
			end
		end
		r.occ = 5'(tbl_fill);
		return r;
	endfunction

	// Offer one request word, optionally after an idle burst; predict once accepted
	task automatic offer_word(logic op, logic [31:0] tag, logic cls, logic [15:0] hnd,
			logic typed, outcome_t typed_want);
		outcome_t r;
		if (bursty && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, hnd, cls, tag};
		do @(posedge clk); while (!s_tready);
		r = sched_outcome(op, tag, cls, hnd);
		words_sent++;
		if (op == OP_TAKE && r.done)
			takes_served++;
		if (!r.done)
			refused++;
		awaited_results.push_back(typed ? typed_want : r);
		in_flight++;
	endtask

	// Stop offering and wait until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		wait (in_flight == 0);
	endtask

	task automatic write_reg(logic [1:0] addr, logic [4:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == REG_POLICY)
			cur_policy = val[1:0];
		else if (addr == REG_WINDOW)
			cur_window = val;
		@(posedge clk);
	endtask

	// Alternating runs of inserts and takes so the table fills and empties; some noise
	task automatic run_traffic(int unsigned count);
		int unsigned left, run_len;
		logic        op;
		logic [31:0] tag;
		left = count;
		op = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_TAKE;
		while (left > 0) begin
			run_len = $urandom_range(1, eff_window() + 4);
			if (run_len > left)
				run_len = left;
			repeat (run_len) begin
				arrival = arrival + 32'($urandom_range(0, 3));
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: tag = 32'($urandom_range(0, 15));
					5, 6:          tag = $urandom;
					7:             tag = 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
					default:       tag = arrival;
				endcase
				offer_word(($urandom_range(0, 9) == 0) ? ~op : op, tag,
					1'($urandom_range(0, 1)), 16'($urandom), 1'b0, NO_OUTCOME);
			end
			left -= run_len;
			op = ~op;
		end
	endtask

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (act_val !== exp_val) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("[%0t] %s mismatch: expected %0h, actual %0h", $time, name,
					exp_val, act_val);
		end
	endtask

	// Result side: ready with random stalls, plus one long hold-off on request
	initial begin : result_sink
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_rx) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end else if (bursty && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Compare each accepted result word with the oldest one awaited
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[31:0], m_tdata[32], m_tdata[48:33], m_tdata[80:49],
				m_tdata[85:81]};
			if (awaited_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("[%0t] unexpected result word: expected none, actual %h",
						$time, got);
			end else begin
				want = awaited_results.pop_front();
				in_flight--;
				check_field("done_res", 32'(want.done), 32'(got.done));
				check_field("out_tag", want.tag, got.tag);
				check_field("out_class", 32'(want.cls), 32'(got.cls));
				check_field("out_handle", 32'(want.hnd), 32'(got.hnd));
				check_field("dispatch_number", want.num, got.num);
				check_field("occupancy", 32'(want.occ), 32'(got.occ));
			end
		end
	end

	// Watchdog: ends the run when no word moves on either side for too long
	initial begin : watchdog
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] timeout: no word moved for %0d cycles, %0d results outstanding",
			$time, quiet, in_flight);
		$display("CHECK FAILED");
		$finish;
	end

	// Main sequence: reset, directed table, random phases, final drain
	initial begin : stimulus
		for (int i = 0; i < SLOTS; i++)
			tbl_valid[i] = 1'b0;
		tbl_fill   = 0;
		take_count = '0;
		cur_policy = POL_OLDEST;
		cur_window = 5'd16;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_REG) begin
				drain();
				write_reg(DIRECTED[i].addr, DIRECTED[i].val);
			end else begin
				offer_word(DIRECTED[i].op, DIRECTED[i].tag, DIRECTED[i].cls, DIRECTED[i].hnd,
					DIRECTED[i].typed, DIRECTED[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			// sender pauses here until the block has returned everything
			drain();
			write_reg(REG_POLICY, {3'($urandom_range(0, 7)), PHASE_POLICY[p]});
			write_reg(REG_WINDOW, PHASE_WINDOW[p]);
			if (p % 4 == 3)
				write_reg((p % 8 == 3) ? REG_UNMAPPED_A : REG_UNMAPPED_B, 5'($urandom));
			bursty = (p < PHASES - 2);
			// receiver holds off while requests keep coming, so the input stalls
			if (p == 5)
				hold_rx = 1'b1;
			run_traffic(PHASE_WORDS);
		end

		drain();
		repeat (SLOTS + 8) @(posedge clk);

		$display("Covered %0d request words over %0d policy/window phases after the table.",
			words_sent, PHASES);
		$display("%0d takes served, %0d operations refused on a full or empty window.",
			takes_served, refused);
		if (errors == 0 && in_flight == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", errors, in_flight);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/cps_pkg.sv
hw/rtl/cps_cell.sv
hw/rtl/class_priority_request_scheduler.sv
bench/class_priority_request_scheduler_tb.sv
